// ===== src/hgrp_pkg.sv =====
// ---------------------------------------------------------------------------
// HTTP GET request line parser package
// Shared types, class codes and literal tables for the request line parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hgrp_pkg;

	// Parser phases; codes above PH_FAIL are treated as a failed line.
	typedef enum logic [3:0] {
		PH_METHOD    = 4'd0,
		PH_URL_FIRST = 4'd1,
		PH_URL       = 4'd2,
		PH_KEY_FIRST = 4'd3,
		PH_KEY       = 4'd4,
		PH_VAL_FIRST = 4'd5,
		PH_VAL       = 4'd6,
		PH_SUFFIX    = 4'd7,
		PH_DONE      = 4'd8,
		PH_FAIL      = 4'd9
	} hgrp_phase_t;

	// Byte classes carried on the result channel.
	typedef enum logic [1:0] {
		CLS_SYNTAX = 2'd0,
		CLS_URL    = 2'd1,
		CLS_KEY    = 2'd2,
		CLS_VALUE  = 2'd3
	} hgrp_class_t;

	localparam logic [3:0] METHOD_LEN = 4'd4;
	localparam logic [3:0] SUFFIX_LEN = 4'd11;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQUAL = 8'h3D;

	// Parser state held between bytes.
	typedef struct packed {
		hgrp_phase_t phase;
		logic [3:0]  literal_index;
	} hgrp_state_t;

	// Per-byte decision handed from the step logic to the result register.
	typedef struct packed {
		logic        line_ok;
		logic        pair_begin;
		hgrp_class_t byte_class;
	} hgrp_res_t;

	// Characters of "GET ".
	function automatic logic [7:0] method_char(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0: ch = 8'h47;
			2'd1: ch = 8'h45;
			2'd2: ch = 8'h54;
			default: ch = CH_SPACE;
		endcase
		return ch;
	endfunction

	// Characters of " HTTP/1.1\r\n"; positions past the end never match a use.
	function automatic logic [7:0] suffix_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:  ch = CH_SPACE;
			4'd1:  ch = 8'h48;
			4'd2:  ch = 8'h54;
			4'd3:  ch = 8'h54;
			4'd4:  ch = 8'h50;
			4'd5:  ch = 8'h2F;
			4'd6:  ch = 8'h31;
			4'd7:  ch = 8'h2E;
			4'd8:  ch = 8'h31;
			4'd9:  ch = 8'h0D;
			4'd10: ch = 8'h0A;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== src/hgrp_step.sv =====
// ---------------------------------------------------------------------------
// Request line parser step logic
// Decides the class of one byte and the parser state that follows it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hgrp_step
	import hgrp_pkg::*;
(
	input  hgrp_state_t cur,
	input  logic [7:0]  data_byte,
	input  logic        line_end,
	output hgrp_state_t nxt,
	output hgrp_res_t   res
);

	logic is_space;
	logic is_query;
	logic is_amp;
	logic is_equal;
	hgrp_state_t adv;

	assign is_space = (data_byte == CH_SPACE);
	assign is_query = (data_byte == CH_QUERY);
	assign is_amp   = (data_byte == CH_AMP);
	assign is_equal = (data_byte == CH_EQUAL);

	always_comb begin
		adv            = cur;
		res.byte_class = CLS_SYNTAX;
		res.pair_begin = 1'b0;
		res.line_ok    = 1'b0;
		case (cur.phase)
			PH_METHOD: begin
				if (cur.literal_index < METHOD_LEN &&
				    data_byte == method_char(cur.literal_index[1:0])) begin
					if (cur.literal_index == METHOD_LEN - 4'd1) begin
						adv.phase         = PH_URL_FIRST;
						adv.literal_index = 4'd0;
					end else begin
						adv.literal_index = cur.literal_index + 4'd1;
					end
				end else begin
					adv.phase = PH_FAIL;
				end
			end
			PH_URL_FIRST: begin
				if (is_space || is_query || is_amp) begin
					adv.phase = PH_FAIL;
				end else begin
					adv.phase      = PH_URL;
					res.byte_class = CLS_URL;
				end
			end
			PH_URL: begin
				if (is_space) begin
					adv.phase         = PH_SUFFIX;
					adv.literal_index = 4'd1;
				end else if (is_query) begin
					adv.phase = PH_KEY_FIRST;
				end else if (is_amp) begin
					adv.phase = PH_FAIL;
				end else begin
					res.byte_class = CLS_URL;
				end
			end
			PH_KEY_FIRST: begin
				if (is_space || is_amp || is_equal) begin
					adv.phase = PH_FAIL;
				end else begin
					adv.phase      = PH_KEY;
					res.byte_class = CLS_KEY;
					res.pair_begin = 1'b1;
				end
			end
			PH_KEY: begin
				if (is_space) begin
					adv.phase         = PH_SUFFIX;
					adv.literal_index = 4'd1;
				end else if (is_amp) begin
					adv.phase = PH_KEY_FIRST;
				end else if (is_equal) begin
					adv.phase = PH_VAL_FIRST;
				end else begin
					res.byte_class = CLS_KEY;
				end
			end
			PH_VAL_FIRST: begin
				if (is_space || is_amp) begin
					adv.phase = PH_FAIL;
				end else begin
					adv.phase      = PH_VAL;
					res.byte_class = CLS_VALUE;
				end
			end
			PH_VAL: begin
				if (is_space) begin
					adv.phase         = PH_SUFFIX;
					adv.literal_index = 4'd1;
				end else if (is_amp) begin
					adv.phase = PH_KEY_FIRST;
				end else begin
					res.byte_class = CLS_VALUE;
				end
			end
			PH_SUFFIX: begin
				if (cur.literal_index < SUFFIX_LEN &&
				    data_byte == suffix_char(cur.literal_index)) begin
					if (cur.literal_index == SUFFIX_LEN - 4'd1) begin
						adv.phase         = PH_DONE;
						adv.literal_index = 4'd0;
					end else begin
						adv.literal_index = cur.literal_index + 4'd1;
					end
				end else begin
					adv.phase = PH_FAIL;
				end
			end
			default: begin
				adv.phase = PH_FAIL;
			end
		endcase

		// The last byte of a line yields the verdict and rearms the parser.
		if (line_end) begin
			res.line_ok       = (adv.phase == PH_DONE);
			nxt.phase         = PH_METHOD;
			nxt.literal_index = 4'd0;
		end else begin
			nxt = adv;
		end
	end

endmodule

`default_nettype wire

// ===== src/http_get_request_line_parser.sv =====
// ---------------------------------------------------------------------------
// HTTP GET request line parser
// Classifies each byte of a request line and reports whether the line parses.
// ---------------------------------------------------------------------------
// The slave stream carries one byte of the request line per beat, with tlast
// on the final byte. The master stream returns one beat for every input beat,
// in order: the byte itself, its class (syntax, URL, key or value), a flag on
// the first byte of every query key, tlast copied from the input and, on the
// tlast beat, the verdict for the whole line.
// An accepted input beat passes through one input register and one result
// register to its result beat, with the classification and the state update
// worked out combinationally between them. One beat is taken per cycle for
// as long as the receiver keeps up; the parser state is a phase code and a
// literal position updated once per byte.
// When the receiver stalls, the result register holds its beat and the input
// register may still take one more beat; tready falls only once both hold.
// Reset empties both registers and returns the parser to the start of a line
// expecting the method. Each line ending with tlast also rearms the parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module http_get_request_line_parser
	import hgrp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output      logic       s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  wire logic       s_axis_tlast,  // line_end
	output      logic       m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output      logic [7:0] m_axis_tdata,  // [7:0] byte_out
	output      logic [3:0] m_axis_tuser,  // [1:0] byte_class, [2] pair_begin, [3] line_ok
	output      logic       m_axis_tlast   // line_done
);

	// Input register stage.
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	// Result register stage.
	logic        valid_s2;
	logic [7:0]  data_s2;
	logic        last_s2;
	hgrp_res_t   res_s2;

	// Parser state, advanced when a byte moves from the input to the result stage.
	hgrp_state_t state_q;
	hgrp_state_t state_nxt;
	hgrp_res_t   res_nxt;

	logic adv_s2;
	logic adv_s1;

	// The result stage can load when it is empty or its beat is being taken.
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	hgrp_step u_step (
		.cur       (state_q),
		.data_byte (data_s1),
		.line_end  (last_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2              <= 1'b0;
			state_q.phase         <= PH_METHOD;
			state_q.literal_index <= 4'd0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			data_s2 <= data_s1;
			last_s2 <= last_s1;
			res_s2  <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tlast  = last_s2;
	assign m_axis_tuser  = {res_s2.line_ok, res_s2.pair_begin, res_s2.byte_class};

endmodule

`default_nettype wire

// ===== src/hgrp_checker.sv =====
// ---------------------------------------------------------------------------
// Request line parser checker
// Port-level assertions on the result stream of the request line parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hgrp_checker
	import hgrp_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic [3:0] m_axis_tuser,
	input wire logic       m_axis_tlast
);

	// A stalled result beat stays put until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser) && $stable(m_axis_tlast))
	else $error("result beat changed while stalled");

	// The verdict is only raised on the final byte of a line.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser[3])
	else $error("line_ok raised before the end of the line");

	// A new parameter always starts with a key byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == CLS_KEY)
	else $error("pair_begin on a byte that is not a key byte");

	// URL bytes never include the separators that end or split the URL.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == CLS_URL |->
		m_axis_tdata != CH_SPACE && m_axis_tdata != CH_QUERY && m_axis_tdata != CH_AMP)
	else $error("separator classed as a URL byte");

	// Key bytes never include space, ampersand or equals.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == CLS_KEY |->
		m_axis_tdata != CH_SPACE && m_axis_tdata != CH_AMP && m_axis_tdata != CH_EQUAL)
	else $error("separator classed as a key byte");

endmodule

bind http_get_request_line_parser hgrp_checker u_hgrp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
